FILE: rtl/core/button_autorepeat_engine_macros.svh
// Assertion macros shared by the button auto-repeat engine RTL.
`ifndef BUTTON_AUTOREPEAT_ENGINE_MACROS_SVH
`define BUTTON_AUTOREPEAT_ENGINE_MACROS_SVH

`ifndef SYNTHESIS
`define BAE_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("button autorepeat engine assertion failed");
`define BAE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("button autorepeat engine assertion failed");
`else
`define BAE_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define BAE_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

FILE: rtl/core/bae_pkg.sv
// Types, constants and the action-to-button map of the button auto-repeat engine.
package bae_pkg;

  localparam int NUM_ACTIONS_DEFAULT = 15;
  localparam int TIME_BITS_DEFAULT = 32;
  localparam int ACT_SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int BTN_W = 16;
  localparam int MASK_W = 15;
  localparam int DELAY_W = 16;
  localparam int STAMP_W = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_DELAY   = 3'd0,
    CFG_SLOW_INTERVAL = 3'd1,
    CFG_FAST_INTERVAL = 3'd2,
    CFG_RAMP_TIME     = 3'd3,
    CFG_REPEAT_ENABLE = 3'd4
  } cfg_reg_t;

  localparam logic [DELAY_W-1:0] FIRST_DELAY_RESET = 16'd380;
  localparam logic [DELAY_W-1:0] SLOW_INTERVAL_RESET = 16'd110;
  localparam logic [DELAY_W-1:0] FAST_INTERVAL_RESET = 16'd45;
  localparam logic [DELAY_W-1:0] RAMP_TIME_RESET = 16'd1500;
  localparam logic [MASK_W-1:0] REPEAT_ENABLE_RESET = 15'h030F;

  localparam logic [BTN_W-1:0] ACT_BIT [ACT_SLOTS] = '{
    16'h0010, 16'h0040, 16'h0080, 16'h0020,
    16'h4000, 16'h2000, 16'h1000, 16'h8000,
    16'h0400, 16'h0800, 16'h0100, 16'h0200,
    16'h0008, 16'h0002, 16'h0004, 16'h0001
  };

  typedef struct packed {
    logic [BTN_W-1:0]   buttons;
    logic [STAMP_W-1:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic [MASK_W-1:0] pressed;
    logic [MASK_W-1:0] repeated;
    logic [MASK_W-1:0] fired;
    logic [BTN_W-1:0]  held_buttons;
    logic [BTN_W-1:0]  new_edges;
    logic              any_new;
  } result_t;

  typedef struct packed {
    logic [DELAY_W-1:0] first_delay_ms;
    logic [DELAY_W-1:0] slow_interval_ms;
    logic [DELAY_W-1:0] fast_interval_ms;
    logic [DELAY_W-1:0] ramp_time_ms;
    logic [MASK_W-1:0]  repeat_enable;
  } cfg_t;

  typedef struct packed {
    logic can_start;
    logic done;
  } eng_status_t;

  function automatic logic [BTN_W-1:0] act_mask(input logic [SLOT_W-1:0] slot);
    return ACT_BIT[slot];
  endfunction

endpackage

FILE: rtl/core/button_autorepeat_engine.sv
// Top level of the button auto-repeat engine: configuration, sample intake and result register.
//
// A pad sample (button word and millisecond time) enters on the sample channel when
// sample_valid is high and sample_stall is low. Each sample yields exactly one result
// transaction on the result channel, taken when result_valid is high and result_stall low.
// The per-action hold start and repeat deadline live in two small RAMs. A sample is
// swept through the actions one per cycle while the sweep is not frozen, reading,
// updating and writing back each action's timers. The next sample can be taken as the
// sweep issues the last action of the current one. Its result passes from the issue and
// process stages into the output register.
// A finished result waits in the output register while the next sample is swept. If the
// receiver stalls and the next sample finishes, the sweep freezes and sample_stall rises
// until the result register is emptied.
// Registers are written on the cfg channel, which is always ready; writes are meant to
// happen while no sample is in flight. Reset restores the register defaults, clears the
// previous button word and marks every action's timers as zero without a clearing pass.
`include "button_autorepeat_engine_macros.svh"

module button_autorepeat_engine #(
  parameter int NUM_ACTIONS = bae_pkg::NUM_ACTIONS_DEFAULT,
  parameter int TIME_BITS = bae_pkg::TIME_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  bae_pkg::sample_t                  sample,
  output logic                              result_valid,
  input  logic                              result_stall,
  output bae_pkg::result_t                  result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bae_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bae_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import bae_pkg::*;

  cfg_t             cfg;
  logic [BTN_W-1:0] last_buttons;
  logic [BTN_W-1:0] edges;
  logic             start;
  logic             advance;
  eng_status_t      status;
  result_t          done_result;

  assign cfg_ready = 1'b1;
  assign edges = sample.buttons & ~last_buttons;
  assign start = sample_valid && status.can_start;
  assign sample_stall = !status.can_start;
  assign advance = !(status.done && result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_delay_ms <= FIRST_DELAY_RESET;
      cfg.slow_interval_ms <= SLOW_INTERVAL_RESET;
      cfg.fast_interval_ms <= FAST_INTERVAL_RESET;
      cfg.ramp_time_ms <= RAMP_TIME_RESET;
      cfg.repeat_enable <= REPEAT_ENABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_FIRST_DELAY: begin
          cfg.first_delay_ms <= cfg_data;
        end
        CFG_SLOW_INTERVAL: begin
          cfg.slow_interval_ms <= cfg_data;
        end
        CFG_FAST_INTERVAL: begin
          cfg.fast_interval_ms <= cfg_data;
        end
        CFG_RAMP_TIME: begin
          cfg.ramp_time_ms <= cfg_data;
        end
        CFG_REPEAT_ENABLE: begin
          cfg.repeat_enable <= cfg_data[MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_buttons <= '0;
      result_valid <= 1'b0;
    end else begin
      if (start) begin
        last_buttons <= sample.buttons;
      end
      if (advance && status.done) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && status.done) begin
      result <= done_result;
    end
  end

  bae_engine #(.NUM_ACTIONS(NUM_ACTIONS), .TIME_BITS(TIME_BITS)) u_engine (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .start_buttons (sample.buttons),
    .start_edges   (edges),
    .start_now     (TIME_BITS'(sample.time_ms)),
    .cfg           (cfg),
    .advance       (advance),
    .status        (status),
    .done_result   (done_result)
  );

  `BAE_ASSERT_SAME(a_full_blocks_intake, clk, rst, status.done && result_valid && result_stall, sample_stall)
  `BAE_ASSERT_SAME(a_fired_is_union, clk, rst, result_valid, result.fired == (result.pressed | result.repeated))
  `BAE_ASSERT_SAME(a_edges_are_held, clk, rst, result_valid, (result.new_edges & ~result.held_buttons) == '0)
  `BAE_ASSERT_NEXT(a_done_loads_result, clk, rst, status.done && !(result_valid && result_stall), result_valid)

endmodule

FILE: rtl/core/bae_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bae_ram #(
  parameter int WIDTH = bae_pkg::TIME_BITS_DEFAULT,
  parameter int DEPTH = bae_pkg::NUM_ACTIONS_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bae_engine.sv
// Per-action sweep: reads the timer RAMs, updates one action a cycle unless frozen and writes back.
module bae_engine #(
  parameter int NUM_ACTIONS = bae_pkg::NUM_ACTIONS_DEFAULT,
  parameter int TIME_BITS = bae_pkg::TIME_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [bae_pkg::BTN_W-1:0]        start_buttons,
  input  logic [bae_pkg::BTN_W-1:0]        start_edges,
  input  logic [TIME_BITS-1:0]             start_now,
  input  bae_pkg::cfg_t                    cfg,
  input  logic                             advance,
  output bae_pkg::eng_status_t             status,
  output bae_pkg::result_t                 done_result
);

  import bae_pkg::*;

  localparam int IDX_W = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ACTIONS - 1);

  logic                 iss_busy;
  logic [IDX_W-1:0]     iss_idx;
  logic [BTN_W-1:0]     iss_buttons;
  logic [BTN_W-1:0]     iss_edges;
  logic [TIME_BITS-1:0] iss_now;
  logic [TIME_BITS-1:0] iss_sum_first;
  logic [TIME_BITS-1:0] iss_sum_slow;
  logic [TIME_BITS-1:0] iss_sum_fast;
  logic                 iss_last;

  logic                 proc_valid;
  logic [IDX_W-1:0]     proc_idx;
  logic                 proc_last;
  logic [BTN_W-1:0]     proc_buttons;
  logic [BTN_W-1:0]     proc_edges;
  logic [TIME_BITS-1:0] proc_now;
  logic [TIME_BITS-1:0] proc_sum_first;
  logic [TIME_BITS-1:0] proc_sum_slow;
  logic [TIME_BITS-1:0] proc_sum_fast;
  logic [ACT_SLOTS-1:0] acc_pressed;
  logic [ACT_SLOTS-1:0] acc_repeated;

  logic                 valid_bits [NUM_ACTIONS];
  logic                 rd_valid;
  logic                 fwd_hit;
  logic [TIME_BITS-1:0] fwd_hold;
  logic [TIME_BITS-1:0] fwd_dead;

  logic [TIME_BITS-1:0] ram_hold;
  logic [TIME_BITS-1:0] ram_dead;
  logic [TIME_BITS-1:0] hold_cur;
  logic [TIME_BITS-1:0] dead_cur;
  logic [TIME_BITS-1:0] hold_new;
  logic [TIME_BITS-1:0] dead_new;
  logic [TIME_BITS-1:0] held;
  logic [SLOT_W-1:0]    slot;
  logic [BTN_W-1:0]     mask;
  logic [ACT_SLOTS-1:0] enable_all;
  logic [ACT_SLOTS-1:0] cur_pressed;
  logic [ACT_SLOTS-1:0] cur_repeated;
  logic                 press_bit;
  logic                 rep_bit;
  logic                 rd_en;
  logic                 wr_en;

  assign iss_last = (iss_idx == LAST_IDX);
  assign rd_en = advance && iss_busy;
  assign wr_en = advance && proc_valid;
  assign status.can_start = advance && (!iss_busy || iss_last);
  assign status.done = proc_valid && proc_last;

  bae_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_ACTIONS)) u_hold_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (proc_idx),
    .wdata (hold_new),
    .re    (rd_en),
    .raddr (iss_idx),
    .rdata (ram_hold)
  );

  bae_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_ACTIONS)) u_dead_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (proc_idx),
    .wdata (dead_new),
    .re    (rd_en),
    .raddr (iss_idx),
    .rdata (ram_dead)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_busy <= 1'b0;
      proc_valid <= 1'b0;
      fwd_hit <= 1'b0;
      for (int i = 0; i < NUM_ACTIONS; i++) begin
        valid_bits[i] <= 1'b0;
      end
    end else if (advance) begin
      if (start) begin
        iss_busy <= 1'b1;
      end else if (iss_last) begin
        iss_busy <= 1'b0;
      end
      proc_valid <= iss_busy;
      if (proc_valid) begin
        valid_bits[proc_idx] <= 1'b1;
      end
      fwd_hit <= proc_valid && iss_busy && (proc_idx == iss_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (start) begin
        iss_idx <= '0;
        iss_buttons <= start_buttons;
        iss_edges <= start_edges;
        iss_now <= start_now;
        iss_sum_first <= start_now + TIME_BITS'(cfg.first_delay_ms);
        iss_sum_slow <= start_now + TIME_BITS'(cfg.slow_interval_ms);
        iss_sum_fast <= start_now + TIME_BITS'(cfg.fast_interval_ms);
      end else if (iss_busy) begin
        iss_idx <= iss_idx + 1'b1;
      end
      proc_idx <= iss_idx;
      proc_last <= iss_last;
      proc_buttons <= iss_buttons;
      proc_edges <= iss_edges;
      proc_now <= iss_now;
      proc_sum_first <= iss_sum_first;
      proc_sum_slow <= iss_sum_slow;
      proc_sum_fast <= iss_sum_fast;
      rd_valid <= valid_bits[iss_idx];
      fwd_hold <= hold_new;
      fwd_dead <= dead_new;
      acc_pressed <= cur_pressed;
      acc_repeated <= cur_repeated;
    end
  end

  always_comb begin
    slot = SLOT_W'(proc_idx);
    mask = act_mask(slot);
    enable_all = {1'b0, cfg.repeat_enable};
    hold_cur = fwd_hit ? fwd_hold : (rd_valid ? ram_hold : '0);
    dead_cur = fwd_hit ? fwd_dead : (rd_valid ? ram_dead : '0);
    held = proc_now - hold_cur;
    hold_new = hold_cur;
    dead_new = dead_cur;
    press_bit = 1'b0;
    rep_bit = 1'b0;
    if ((proc_buttons & mask) == '0) begin
      hold_new = '0;
      dead_new = '0;
    end else if ((proc_edges & mask) != '0) begin
      press_bit = 1'b1;
      hold_new = proc_now;
      dead_new = proc_sum_first;
    end else if (enable_all[slot] && (proc_now >= dead_cur)) begin
      rep_bit = 1'b1;
      dead_new = (held < TIME_BITS'(cfg.ramp_time_ms)) ? proc_sum_slow : proc_sum_fast;
    end
    cur_pressed = ((proc_idx == '0) ? '0 : acc_pressed)
                  | (press_bit ? (ACT_SLOTS'(1) << slot) : '0);
    cur_repeated = ((proc_idx == '0) ? '0 : acc_repeated)
                   | (rep_bit ? (ACT_SLOTS'(1) << slot) : '0);
    done_result.pressed = cur_pressed[MASK_W-1:0];
    done_result.repeated = cur_repeated[MASK_W-1:0];
    done_result.fired = cur_pressed[MASK_W-1:0] | cur_repeated[MASK_W-1:0];
    done_result.held_buttons = proc_buttons;
    done_result.new_edges = proc_edges;
    done_result.any_new = |proc_edges;
  end

endmodule
